// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TESR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TESR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tesr_pkg.sv
// ----------------------------------------------------------------------------
// tesr_pkg
// Types, widths and constants of the trail even spacing resampler.
// ----------------------------------------------------------------------------
package tesr_pkg;

   localparam int MAX_SEGMENTS = 256;
   localparam int HIT_FIRST    = 10;

   localparam logic [1:0] REG_SPACING   = 2'd0;
   localparam logic [1:0] REG_SEG_COUNT = 2'd1;
   localparam logic [1:0] REG_HIT_RAD   = 2'd2;
   localparam logic [1:0] REG_COLL_EN   = 2'd3;

   localparam logic [15:0] SPACING_RST   = 16'd2560;
   localparam logic [8:0]  SEG_COUNT_RST = 9'd10;
   localparam logic [15:0] HIT_RAD_RST   = 16'd2560;

   localparam logic [25:0] ACC_MAX = 26'h3FFFFFF;
   localparam logic signed [54:0] C24_MAX = 55'sd8388607;
   localparam logic signed [54:0] C24_MIN = -55'sd8388608;

   localparam logic [5:0] SQ_STEPS   = 6'd25;
   localparam logic [5:0] ROOT_STEPS = 6'd25;
   localparam logic [5:0] MUL_STEPS  = 6'd27;
   localparam logic [5:0] DIV_STEPS  = 6'd53;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SQ   = 7'b0000010,
      ST_ROOT = 7'b0000100,
      ST_MUL  = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_HSQ  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [15:0] spacing;
      logic [8:0]  segment_count;
      logic [15:0] hit_radius;
      logic        collision_enable;
   } cfg_type;

   typedef struct packed {
      logic signed [23:0] head_x;
      logic signed [23:0] head_y;
      logic signed [23:0] prev_x;
      logic signed [23:0] prev_y;
      logic signed [23:0] cur_x;
      logic signed [23:0] cur_y;
      logic [25:0] acc;
      logic [24:0] dxm;
      logic [24:0] dym;
      logic        dx_neg;
      logic        dy_neg;
      logic        ex_neg;
      logic [51:0] ma_x;
      logic [51:0] ma_y;
      logic [26:0] mb_x;
      logic [26:0] mb_y;
      logic [51:0] pr_x;
      logic [51:0] pr_y;
      logic [31:0] rma;
      logic [15:0] rmb;
      logic [31:0] rpr;
      logic [49:0] rad;
      logic [24:0] root;
      logic [26:0] rrem;
      logic [52:0] num_x;
      logic [52:0] num_y;
      logic [25:0] rem_x;
      logic [25:0] rem_y;
      logic signed [23:0] res_x;
      logic signed [23:0] res_y;
      logic        hit;
   } work_type;

endpackage

// File: rtl/tesr_if.sv
// ----------------------------------------------------------------------------
// tesr_if
// Valid/ready channels of the resampler: trail points, segments, registers.
// ----------------------------------------------------------------------------
interface tesr_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] point_x;
   logic signed [23:0] point_y;
   logic               trail_start;
   modport source (output valid, point_x, point_y, trail_start, input ready);
   modport sink   (input valid, point_x, point_y, trail_start, output ready);
endinterface

interface tesr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] seg_x;
   logic signed [23:0] seg_y;
   logic [7:0]         seg_index;
   logic               hits_head;
   logic               last;
   modport source (output valid, seg_x, seg_y, seg_index, hits_head, last, input ready);
   modport sink   (input valid, seg_x, seg_y, seg_index, hits_head, last, output ready);
endinterface

interface tesr_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/trail_even_spacing_resampler.sv
// ----------------------------------------------------------------------------
// trail_even_spacing_resampler
// Resamples a newest-first trail into segments one spacing apart.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries trail points; a point with trail_start set is the head and
//   yields segment 0. Each later point closes a step; a step that reaches the
//   spacing yields one interpolated segment on rsp_ch, others yield nothing.
//   csr_ch writes spacing, segment_count, hit_radius and collision_enable;
//   write only while the block is idle.
// Sequencing:
//   One request at a time. A head goes through ST_OUT to its output register.
//   A step without a segment runs serial squaring, then a bit-pair square root;
//   a step with a segment adds a 27-step serial multiply, a 53-step restoring
//   divide and, from index 10 on with collision_enable set, a head distance
//   check on the serial lanes. A point after the count is reached or before
//   any head is taken is dropped.
// Reset:
//   Registers return to their defaults, trail state clears, waiting for a head.
// Stall:
//   The output register holds a segment until rsp_ch.ready; the next request
//   is taken meanwhile and its result waits in the last state for the slot.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trail_even_spacing_resampler (
   input  logic       clock,
   input  logic       reset,
   tesr_req_if.sink   req_ch,
   tesr_rsp_if.source rsp_ch,
   tesr_csr_if.sink   csr_ch
);

   tesr_pkg::state_type state_ff, state_in;
   tesr_pkg::cfg_type   cfg_ff, cfg_in;
   tesr_pkg::work_type  w_ff, w_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [8:0] emitted_ff, emitted_in;
   logic       active_ff, active_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [7:0]         rsp_idx_ff, rsp_idx_in;
   logic               rsp_hit_ff, rsp_hit_in, rsp_last_ff, rsp_last_in;

   logic [8:0]  eff_count;
   logic        req_take, slot_free;
   logic [51:0] lx_pr, ly_pr;
   logic [31:0] lr_pr;
   logic [28:0] sq_r4, sq_t;
   logic        sq_ge;
   logic [24:0] sq_root;
   logic [26:0] sq_rem;
   logic [26:0] dv_rx, dv_ry, dv_d;
   logic        dv_qx, dv_qy;
   logic [24:0] dx, dy;
   logic [26:0] total, excess, acc_next;
   logic        emit;
   logic        go_hit;
   logic signed [23:0] res_x_c, res_y_c;
   logic [52:0] qx, qy;
   logic signed [54:0] qsx, qsy, sx, sy;
   logic [50:0] dist2;

   always_comb begin
      if (cfg_ff.segment_count == 9'd0) begin
         eff_count = 9'd1;
      end else if (cfg_ff.segment_count > 9'(tesr_pkg::MAX_SEGMENTS)) begin
         eff_count = 9'(tesr_pkg::MAX_SEGMENTS);
      end else begin
         eff_count = cfg_ff.segment_count;
      end
   end

   assign req_ch.ready = (state_ff == tesr_pkg::ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   // serial lanes, one multiplier bit per cycle
   assign lx_pr = w_ff.mb_x[0] ? w_ff.pr_x + w_ff.ma_x : w_ff.pr_x;
   assign ly_pr = w_ff.mb_y[0] ? w_ff.pr_y + w_ff.ma_y : w_ff.pr_y;
   assign lr_pr = w_ff.rmb[0]  ? w_ff.rpr + w_ff.rma   : w_ff.rpr;

   // square root, one result bit per cycle
   assign sq_r4   = {w_ff.rrem, w_ff.rad[49:48]};
   assign sq_t    = {2'b00, w_ff.root, 2'b01};
   assign sq_ge   = (sq_r4 >= sq_t);
   assign sq_root = {w_ff.root[23:0], sq_ge};
   assign sq_rem  = sq_ge ? 27'(sq_r4 - sq_t) : sq_r4[26:0];

   // restoring division, one quotient bit per cycle
   assign dv_d  = {2'b00, w_ff.root};
   assign dv_rx = {w_ff.rem_x, w_ff.num_x[52]};
   assign dv_ry = {w_ff.rem_y, w_ff.num_y[52]};
   assign dv_qx = (dv_rx >= dv_d);
   assign dv_qy = (dv_ry >= dv_d);

   assign dx = 25'({w_ff.prev_x[23], w_ff.prev_x});
   assign dy = 25'({w_ff.prev_y[23], w_ff.prev_y});

   assign total    = {1'b0, w_ff.acc} + {2'b00, sq_root};
   assign emit     = (total >= {11'd0, cfg_ff.spacing});
   assign excess   = {11'd0, cfg_ff.spacing} - {1'b0, w_ff.acc};
   assign acc_next = emit ? total - {11'd0, cfg_ff.spacing} : total;

   assign qx  = {w_ff.num_x[51:0], dv_qx};
   assign qy  = {w_ff.num_y[51:0], dv_qy};
   assign qsx = (w_ff.dx_neg ^ w_ff.ex_neg) ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
   assign qsy = (w_ff.dy_neg ^ w_ff.ex_neg) ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
   assign sx  = 55'(w_ff.prev_x) + qsx;
   assign sy  = 55'(w_ff.prev_y) + qsy;

   assign dist2 = {1'b0, lx_pr[49:0]} + {1'b0, ly_pr[49:0]};

   always_comb begin
      logic [24:0] pdx, pdy;
      state_in     = state_ff;
      cfg_in       = cfg_ff;
      w_in         = w_ff;
      cnt_in       = cnt_ff;
      emitted_in   = emitted_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_last_in  = rsp_last_ff;
      go_hit       = 1'b0;
      res_x_c      = w_ff.prev_x;
      res_y_c      = w_ff.prev_y;
      pdx          = 25'({req_ch.point_x[23], req_ch.point_x}) - dx;
      pdy          = 25'({req_ch.point_y[23], req_ch.point_y}) - dy;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            tesr_pkg::REG_SPACING:   cfg_in.spacing          = csr_ch.data;
            tesr_pkg::REG_SEG_COUNT: cfg_in.segment_count    = csr_ch.data[8:0];
            tesr_pkg::REG_HIT_RAD:   cfg_in.hit_radius       = csr_ch.data;
            tesr_pkg::REG_COLL_EN:   cfg_in.collision_enable = csr_ch.data[0];
            default: cfg_in = cfg_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         tesr_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_ch.trail_start) begin
                  w_in.head_x = req_ch.point_x;
                  w_in.head_y = req_ch.point_y;
                  w_in.prev_x = req_ch.point_x;
                  w_in.prev_y = req_ch.point_y;
                  w_in.cur_x  = req_ch.point_x;
                  w_in.cur_y  = req_ch.point_y;
                  w_in.res_x  = req_ch.point_x;
                  w_in.res_y  = req_ch.point_y;
                  w_in.acc    = '0;
                  w_in.hit    = 1'b0;
                  emitted_in  = '0;
                  active_in   = 1'b1;
                  state_in    = tesr_pkg::ST_OUT;
               end else if (active_ff && (emitted_ff < eff_count)) begin
                  w_in.cur_x  = req_ch.point_x;
                  w_in.cur_y  = req_ch.point_y;
                  w_in.dx_neg = pdx[24];
                  w_in.dy_neg = pdy[24];
                  w_in.dxm    = pdx[24] ? -pdx : pdx;
                  w_in.dym    = pdy[24] ? -pdy : pdy;
                  w_in.ma_x   = {27'd0, w_in.dxm};
                  w_in.ma_y   = {27'd0, w_in.dym};
                  w_in.mb_x   = {2'b00, w_in.dxm};
                  w_in.mb_y   = {2'b00, w_in.dym};
                  w_in.pr_x   = '0;
                  w_in.pr_y   = '0;
                  cnt_in      = tesr_pkg::SQ_STEPS - 6'd1;
                  state_in    = tesr_pkg::ST_SQ;
               end
            end
         end
         tesr_pkg::ST_SQ: begin
            w_in.pr_x = lx_pr;
            w_in.pr_y = ly_pr;
            w_in.ma_x = {w_ff.ma_x[50:0], 1'b0};
            w_in.ma_y = {w_ff.ma_y[50:0], 1'b0};
            w_in.mb_x = {1'b0, w_ff.mb_x[26:1]};
            w_in.mb_y = {1'b0, w_ff.mb_y[26:1]};
            cnt_in    = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               w_in.rad  = lx_pr[49:0] + ly_pr[49:0];
               w_in.root = '0;
               w_in.rrem = '0;
               cnt_in    = tesr_pkg::ROOT_STEPS - 6'd1;
               state_in  = tesr_pkg::ST_ROOT;
            end
         end
         tesr_pkg::ST_ROOT: begin
            w_in.root = sq_root;
            w_in.rrem = sq_rem;
            w_in.rad  = {w_ff.rad[47:0], 2'b00};
            cnt_in    = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               w_in.acc = acc_next[26] ? tesr_pkg::ACC_MAX : acc_next[25:0];
               if (!emit) begin
                  w_in.prev_x = w_ff.cur_x;
                  w_in.prev_y = w_ff.cur_y;
                  state_in    = tesr_pkg::ST_IDLE;
               end else if (sq_root == 25'd0) begin
                  go_hit = 1'b1;
               end else begin
                  w_in.ex_neg = excess[26];
                  w_in.ma_x   = {27'd0, w_ff.dxm};
                  w_in.ma_y   = {27'd0, w_ff.dym};
                  w_in.mb_x   = excess[26] ? -excess : excess;
                  w_in.mb_y   = excess[26] ? -excess : excess;
                  w_in.pr_x   = '0;
                  w_in.pr_y   = '0;
                  cnt_in      = tesr_pkg::MUL_STEPS - 6'd1;
                  state_in    = tesr_pkg::ST_MUL;
               end
            end
         end
         tesr_pkg::ST_MUL: begin
            w_in.pr_x = lx_pr;
            w_in.pr_y = ly_pr;
            w_in.ma_x = {w_ff.ma_x[50:0], 1'b0};
            w_in.ma_y = {w_ff.ma_y[50:0], 1'b0};
            w_in.mb_x = {1'b0, w_ff.mb_x[26:1]};
            w_in.mb_y = {1'b0, w_ff.mb_y[26:1]};
            cnt_in    = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               w_in.num_x = {1'b0, lx_pr} + {29'd0, w_ff.root[24:1]};
               w_in.num_y = {1'b0, ly_pr} + {29'd0, w_ff.root[24:1]};
               w_in.rem_x = '0;
               w_in.rem_y = '0;
               cnt_in     = tesr_pkg::DIV_STEPS - 6'd1;
               state_in   = tesr_pkg::ST_DIV;
            end
         end
         tesr_pkg::ST_DIV: begin
            w_in.rem_x = dv_qx ? 26'(dv_rx - dv_d) : dv_rx[25:0];
            w_in.rem_y = dv_qy ? 26'(dv_ry - dv_d) : dv_ry[25:0];
            w_in.num_x = qx;
            w_in.num_y = qy;
            cnt_in     = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               res_x_c = (sx > tesr_pkg::C24_MAX) ? 24'sd8388607 :
                         (sx < tesr_pkg::C24_MIN) ? -24'sd8388608 : sx[23:0];
               res_y_c = (sy > tesr_pkg::C24_MAX) ? 24'sd8388607 :
                         (sy < tesr_pkg::C24_MIN) ? -24'sd8388608 : sy[23:0];
               go_hit  = 1'b1;
            end
         end
         tesr_pkg::ST_HSQ: begin
            w_in.pr_x = lx_pr;
            w_in.pr_y = ly_pr;
            w_in.rpr  = lr_pr;
            w_in.ma_x = {w_ff.ma_x[50:0], 1'b0};
            w_in.ma_y = {w_ff.ma_y[50:0], 1'b0};
            w_in.mb_x = {1'b0, w_ff.mb_x[26:1]};
            w_in.mb_y = {1'b0, w_ff.mb_y[26:1]};
            w_in.rma  = {w_ff.rma[30:0], 1'b0};
            w_in.rmb  = {1'b0, w_ff.rmb[15:1]};
            cnt_in    = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               w_in.hit = (dist2 < {19'd0, lr_pr});
               state_in = tesr_pkg::ST_OUT;
            end
         end
         tesr_pkg::ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = w_ff.res_x;
               rsp_y_in     = w_ff.res_y;
               rsp_idx_in   = emitted_ff[7:0];
               rsp_hit_in   = w_ff.hit;
               rsp_last_in  = ({1'b0, emitted_ff} + 10'd1) == {1'b0, eff_count};
               emitted_in   = emitted_ff + 9'd1;
               w_in.prev_x  = w_ff.cur_x;
               w_in.prev_y  = w_ff.cur_y;
               state_in     = tesr_pkg::ST_IDLE;
            end
         end
         default: state_in = tesr_pkg::ST_IDLE;
      endcase

      if (go_hit) begin
         w_in.res_x = res_x_c;
         w_in.res_y = res_y_c;
         if ((emitted_ff >= 9'(tesr_pkg::HIT_FIRST)) && cfg_ff.collision_enable) begin
            pdx       = {res_x_c[23], res_x_c} - {w_ff.head_x[23], w_ff.head_x};
            pdy       = {res_y_c[23], res_y_c} - {w_ff.head_y[23], w_ff.head_y};
            w_in.ma_x = {27'd0, pdx[24] ? -pdx : pdx};
            w_in.ma_y = {27'd0, pdy[24] ? -pdy : pdy};
            w_in.mb_x = {2'b00, pdx[24] ? -pdx : pdx};
            w_in.mb_y = {2'b00, pdy[24] ? -pdy : pdy};
            w_in.pr_x = '0;
            w_in.pr_y = '0;
            w_in.rma  = {16'd0, cfg_ff.hit_radius};
            w_in.rmb  = cfg_ff.hit_radius;
            w_in.rpr  = '0;
            cnt_in    = tesr_pkg::SQ_STEPS - 6'd1;
            state_in  = tesr_pkg::ST_HSQ;
         end else begin
            w_in.hit  = 1'b0;
            state_in  = tesr_pkg::ST_OUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tesr_pkg::ST_IDLE;
         cfg_ff       <= '{tesr_pkg::SPACING_RST, tesr_pkg::SEG_COUNT_RST,
                           tesr_pkg::HIT_RAD_RST, 1'b1};
         cnt_ff       <= '0;
         emitted_ff   <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         w_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         cnt_ff       <= cnt_in;
         emitted_ff   <= emitted_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         w_ff         <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.seg_x     = rsp_x_ff;
   assign rsp_ch.seg_y     = rsp_y_ff;
   assign rsp_ch.seg_index = rsp_idx_ff;
   assign rsp_ch.hits_head = rsp_hit_ff;
   assign rsp_ch.last      = rsp_last_ff;

   `TESR_ASSERT_IMP(a_div_rem_bound, state_ff == tesr_pkg::ST_DIV,
      {1'b0, w_ff.rem_x} < dv_d, "divider remainder not below divisor")
   `TESR_ASSERT_IMP(a_root_rem_bound, state_ff == tesr_pkg::ST_ROOT,
      {1'b0, w_ff.rrem} <= {2'b00, w_ff.root, 1'b0}, "root remainder above twice root")
   `TESR_ASSERT_NXT(a_emit_count, (state_ff == tesr_pkg::ST_OUT) && slot_free,
      rsp_valid_ff && (emitted_ff == $past(emitted_ff) + 9'd1), "segment not counted")
   `TESR_ASSERT_IMP(a_count_cap, 1'b1,
      emitted_ff <= 9'(tesr_pkg::MAX_SEGMENTS), "segment count past maximum")

endmodule
